>>> rtl/gts_pkg.sv
`timescale 1ns / 1ps

package gts_pkg;

  // Field widths fixed by the item format.
  localparam int NODE_W   = 6;
  localparam int REQ_W    = 3;
  localparam int SLOT_W   = 3;
  localparam int WIN_W    = 16;
  localparam int DEGIN_W  = 4;
  localparam int RAND_W   = 16;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [MODE_W-1:0]   mode_t;

  // Request codes.
  localparam req_t REQ_EDGE    = 3'd0;
  localparam req_t REQ_DEGREE  = 3'd1;
  localparam req_t REQ_RESTART = 3'd2;
  localparam req_t REQ_STEP    = 3'd3;
  localparam req_t REQ_REPORT  = 3'd4;
  localparam req_t REQ_SETSTRT = 3'd5;

  // Walk modes.
  localparam mode_t MODE_RANDOM = 2'd0;
  localparam mode_t MODE_DFS    = 2'd1;
  localparam mode_t MODE_BFS    = 2'd2;

  // Result status codes.
  localparam status_t ST_NODE         = 3'd0;
  localparam status_t ST_DONE         = 3'd1;
  localparam status_t ST_ACK          = 3'd2;
  localparam status_t ST_NOSTART      = 3'd3;
  localparam status_t ST_ABSENT_START = 3'd4;
  localparam status_t ST_OVERFLOW     = 3'd5;
  localparam status_t ST_NOCUR        = 3'd6;
  localparam status_t ST_ABSENT       = 3'd7;

  // Operation of the shared arithmetic unit.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

endpackage

>>> rtl/gts_ram.sv
`timescale 1ns / 1ps

module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/gts_alu.sv
`timescale 1ns / 1ps

module gts_alu #(
  parameter int W = 8
) (
  input  gts_pkg::alu_op_e op_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [W-1:0]     res_o,
  output logic             borrow_o
);

  logic [W:0] full;

  // Shared adder and subtractor; the top bit is the carry or the borrow.
  always_comb begin
    case (op_i)
      gts_pkg::ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      gts_pkg::ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      default:          full = {1'b0, a_i} + {1'b0, b_i};
    endcase
  end

  assign res_o    = full[W-1:0];
  assign borrow_o = full[W];

endmodule

>>> rtl/graph_traversal_stepper.sv
`timescale 1ns / 1ps
// Loads, set start, report and acks answer from the decode state; a restart answers from start.
// A depth-first step pops stale stack entries until it finds an unvisited node; a random step
// sums the weights and scans them, or with all weights zero takes a bit-serial modulo of the draw.
// A step that must first start the walk passes through start; a step after done answers from decode.
// One item at a time; busy is high from acceptance until the result strobe.
// Reset clears all control state, presence and visit bits; the receiver cannot stall.
module graph_traversal_stepper #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_DEGREE  = 8,
  parameter int WORK_DEPTH  = 512,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [gts_pkg::MODE_W-1:0]    cfg_wdata_i,
  input  logic [gts_pkg::REQ_W-1:0]     req_type_i,
  input  logic [gts_pkg::NODE_W-1:0]    node_id_i,
  input  logic [gts_pkg::SLOT_W-1:0]    edge_slot_i,
  input  logic [gts_pkg::NODE_W-1:0]    edge_target_i,
  input  logic [gts_pkg::WIN_W-1:0]     edge_weight_i,
  input  logic [gts_pkg::DEGIN_W-1:0]   node_degree_i,
  input  logic                          has_start_i,
  input  logic [gts_pkg::RAND_W-1:0]    rand_value_i,
  output logic                          result_valid_o,
  output logic [gts_pkg::NODE_W-1:0]    out_node_o,
  output logic [gts_pkg::STATUS_W-1:0]  status_o
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int EDGES = MAX_NODES * MAX_DEGREE;
  localparam int EA_W  = $clog2(EDGES);
  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int WA_W  = $clog2(WORK_DEPTH);
  localparam int WP_W  = $clog2(WORK_DEPTH + 1);
  localparam int TOT_W = WEIGHT_BITS + DEG_W;
  localparam int PR_W  = TOT_W + gts_pkg::RAND_W;
  localparam int ED_W  = gts_pkg::NODE_W + WEIGHT_BITS;
  localparam int RW    = gts_pkg::RAND_W;
  localparam int NW    = gts_pkg::NODE_W;

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DEC      = 18'h00002,
    S_START    = 18'h00004,
    S_STEP     = 18'h00008,
    S_RND_DEG  = 18'h00010,
    S_RND_SUM  = 18'h00020,
    S_RND_MUL  = 18'h00040,
    S_RND_SCAN = 18'h00080,
    S_RND_DIV  = 18'h00100,
    S_RND_PICK = 18'h00200,
    S_DFS_POP  = 18'h00400,
    S_DFS_CHK  = 18'h00800,
    S_DFS_DEG  = 18'h01000,
    S_DFS_EXP  = 18'h02000,
    S_BFS_POP  = 18'h04000,
    S_BFS_CHK  = 18'h08000,
    S_BFS_DEG  = 18'h10000,
    S_BFS_EXP  = 18'h20000
  } state_e;

  // Control state.
  state_e                     state_q, state_d;
  gts_pkg::mode_t             mode_q, mode_d;
  logic [MAX_NODES-1:0]       present_q, present_d;
  logic [MAX_NODES-1:0]       visited_q, visited_d;
  logic [WP_W-1:0]            head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]              cur_q, cur_d;
  logic                       cv_q, cv_d;
  logic [NW-1:0]              rs_q, rs_d;
  logic                       sv_q, sv_d;
  logic                       init_q, init_d;
  logic                       done_q, done_d;
  logic                       rv_q, rv_d;

  // Item and datapath registers.
  gts_pkg::req_t              req_q, req_d;
  logic [NW-1:0]              node_q, node_d;
  logic [gts_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [NW-1:0]              tgt_q, tgt_d;
  logic [gts_pkg::WIN_W-1:0]  wgt_q, wgt_d;
  logic [gts_pkg::DEGIN_W-1:0] degin_q, degin_d;
  logic                       hs_q, hs_d;
  logic [RW-1:0]              rand_q, rand_d;
  logic [DEG_W-1:0]           deg_q, deg_d;
  logic [DEG_W-1:0]           ei_q, ei_d;
  logic [TOT_W-1:0]           tot_q, tot_d;
  logic [TOT_W-1:0]           cum_q, cum_d;
  logic [TOT_W-1:0]           r_q, r_d;
  logic [TOT_W-1:0]           rem_q, rem_d;
  logic [RW-1:0]              rsh_q, rsh_d;
  logic [3:0]                 cnt_q, cnt_d;
  gts_pkg::status_t           st_q, st_d;
  logic [NW-1:0]              on_q, on_d;
  gts_pkg::status_t           os_q, os_d;

  // Memory ports.
  logic                       edge_we;
  logic [EA_W-1:0]            edge_waddr, edge_raddr;
  logic [ED_W-1:0]            edge_wdata, edge_rdata;
  logic                       deg_we;
  logic [IDX_W-1:0]           deg_waddr, deg_raddr;
  logic [DEG_W-1:0]           deg_wdata, deg_rdata;
  logic                       work_we;
  logic [WA_W-1:0]            work_waddr, work_raddr;
  logic [NW-1:0]              work_wdata, work_rdata;

  // Shared arithmetic unit.
  gts_pkg::alu_op_e           alu_op;
  logic [TOT_W-1:0]           alu_a, alu_b, alu_res;
  logic                       alu_borrow;

  logic [DEG_W-1:0]           e_idx;
  logic [PR_W-1:0]            prod;
  logic [NW-1:0]              e_tgt;
  logic [WEIGHT_BITS-1:0]     e_wgt;
  logic [TOT_W-1:0]           trial;
  logic                       room;

  function automatic logic in_range(input logic [NW-1:0] n);
    return 32'(n) < MAX_NODES;
  endfunction

  function automatic logic bit_of(input logic [NW-1:0] n, input logic [MAX_NODES-1:0] bits);
    return in_range(n) && bits[IDX_W'(n)];
  endfunction

  gts_ram #(.WIDTH(ED_W), .DEPTH(EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  gts_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  gts_ram #(.WIDTH(NW), .DEPTH(WORK_DEPTH)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (work_raddr),
    .rdata_o (work_rdata)
  );

  gts_alu #(.W(TOT_W)) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // Fixed wiring around the memories.
  assign e_tgt      = edge_rdata[ED_W-1:WEIGHT_BITS];
  assign e_wgt      = edge_rdata[WEIGHT_BITS-1:0];
  assign edge_waddr = EA_W'(32'(node_q) * MAX_DEGREE + 32'(slot_q));
  assign edge_wdata = {tgt_q, WEIGHT_BITS'(wgt_q)};
  assign edge_raddr = EA_W'(32'(cur_q) * MAX_DEGREE + 32'(e_idx));
  assign deg_waddr  = IDX_W'(node_q);
  assign deg_wdata  = (32'(degin_q) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(degin_q);
  assign prod       = PR_W'(rand_q) * PR_W'(tot_q);
  assign trial      = {rem_q[TOT_W-2:0], rsh_q[RW-1]};
  assign room       = 32'(tail_q) < WORK_DEPTH;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    present_d = present_q;
    visited_d = visited_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cur_d     = cur_q;
    cv_d      = cv_q;
    rs_d      = rs_q;
    sv_d      = sv_q;
    init_d    = init_q;
    done_d    = done_q;
    rv_d      = 1'b0;
    req_d     = req_q;
    node_d    = node_q;
    slot_d    = slot_q;
    tgt_d     = tgt_q;
    wgt_d     = wgt_q;
    degin_d   = degin_q;
    hs_d      = hs_q;
    rand_d    = rand_q;
    deg_d     = deg_q;
    ei_d      = ei_q;
    tot_d     = tot_q;
    cum_d     = cum_q;
    r_d       = r_q;
    rem_d     = rem_q;
    rsh_d     = rsh_q;
    cnt_d     = cnt_q;
    st_d      = st_q;
    on_d      = on_q;
    os_d      = os_q;
    edge_we   = 1'b0;
    deg_we    = 1'b0;
    work_we   = 1'b0;
    work_waddr = WA_W'(tail_q);
    work_wdata = edge_rdata[ED_W-1:WEIGHT_BITS];
    work_raddr = WA_W'(head_q);
    deg_raddr  = IDX_W'(cur_q);
    e_idx      = ei_q;
    alu_op     = gts_pkg::ALU_ADD;
    alu_a      = cum_q;
    alu_b      = TOT_W'(e_wgt);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_type_i;
          node_d  = node_id_i;
          slot_d  = edge_slot_i;
          tgt_d   = edge_target_i;
          wgt_d   = edge_weight_i;
          degin_d = node_degree_i;
          hs_d    = has_start_i;
          rand_d  = rand_value_i;
          state_d = S_DEC;
        end else if (cfg_we_i && (cfg_wdata_i == gts_pkg::MODE_RANDOM ||
                                  cfg_wdata_i == gts_pkg::MODE_DFS ||
                                  cfg_wdata_i == gts_pkg::MODE_BFS)) begin
          // A mode write restarts the traversal bookkeeping.
          mode_d    = cfg_wdata_i;
          visited_d = '0;
          head_d    = '0;
          tail_d    = '0;
          init_d    = 1'b0;
          done_d    = 1'b0;
        end
      end

      S_DEC: begin
        rv_d    = 1'b1;
        on_d    = '0;
        os_d    = gts_pkg::ST_ACK;
        state_d = S_IDLE;
        case (req_q)
          gts_pkg::REQ_EDGE: begin
            edge_we = in_range(node_q) && (32'(slot_q) < MAX_DEGREE);
          end
          gts_pkg::REQ_DEGREE: begin
            if (in_range(node_q)) begin
              deg_we                   = 1'b1;
              present_d[IDX_W'(node_q)] = 1'b1;
            end
          end
          gts_pkg::REQ_SETSTRT: begin
            rs_d = node_q;
            sv_d = 1'b1;
          end
          gts_pkg::REQ_REPORT: begin
            if (!cv_q) begin
              os_d = gts_pkg::ST_NOCUR;
            end else begin
              on_d = cur_q;
              os_d = bit_of(cur_q, present_q) ? gts_pkg::ST_NODE : gts_pkg::ST_ABSENT;
            end
          end
          gts_pkg::REQ_RESTART: begin
            rv_d = 1'b0;
            if (hs_q) begin
              rs_d = node_q;
              sv_d = 1'b1;
            end
            state_d = S_START;
          end
          gts_pkg::REQ_STEP: begin
            if (done_q) begin
              on_d = cur_q;
              os_d = gts_pkg::ST_DONE;
            end else begin
              rv_d    = 1'b0;
              state_d = init_q ? S_STEP : S_START;
            end
          end
          default: begin
          end
        endcase
      end

      // Start from the remembered node, seeding the work store in the search modes.
      S_START: begin
        if (!sv_q) begin
          rv_d    = 1'b1;
          on_d    = '0;
          os_d    = gts_pkg::ST_NOSTART;
          state_d = S_IDLE;
        end else if (!bit_of(rs_q, present_q)) begin
          rv_d    = 1'b1;
          on_d    = rs_q;
          os_d    = gts_pkg::ST_ABSENT_START;
          state_d = S_IDLE;
        end else begin
          visited_d  = '0;
          head_d     = '0;
          tail_d     = '0;
          done_d     = 1'b0;
          cur_d      = rs_q;
          cv_d       = 1'b1;
          init_d     = 1'b1;
          work_waddr = '0;
          work_wdata = rs_q;
          if (mode_q == gts_pkg::MODE_DFS || mode_q == gts_pkg::MODE_BFS) begin
            work_we = 1'b1;
            tail_d  = WP_W'(1);
          end
          if (mode_q == gts_pkg::MODE_BFS) begin
            visited_d[IDX_W'(rs_q)] = 1'b1;
          end
          if (req_q == gts_pkg::REQ_RESTART) begin
            rv_d    = 1'b1;
            on_d    = rs_q;
            os_d    = gts_pkg::ST_ACK;
            state_d = S_IDLE;
          end else begin
            state_d = S_STEP;
          end
        end
      end

      S_STEP: begin
        case (mode_q)
          gts_pkg::MODE_DFS: state_d = S_DFS_POP;
          gts_pkg::MODE_BFS: state_d = S_BFS_POP;
          default: begin
            if (!bit_of(cur_q, present_q)) begin
              rv_d    = 1'b1;
              on_d    = cur_q;
              os_d    = gts_pkg::ST_ABSENT;
              state_d = S_IDLE;
            end else begin
              state_d = S_RND_DEG;
            end
          end
        endcase
      end

      // Weighted random walk.
      S_RND_DEG: begin
        deg_d = deg_rdata;
        if (deg_rdata == '0) begin
          done_d  = 1'b1;
          rv_d    = 1'b1;
          on_d    = cur_q;
          os_d    = gts_pkg::ST_DONE;
          state_d = S_IDLE;
        end else begin
          ei_d    = '0;
          e_idx   = '0;
          tot_d   = '0;
          state_d = S_RND_SUM;
        end
      end

      S_RND_SUM: begin
        alu_a = tot_q;
        tot_d = alu_res;
        if (ei_q + DEG_W'(1) < deg_q) begin
          ei_d  = ei_q + DEG_W'(1);
          e_idx = ei_d;
        end else begin
          state_d = S_RND_MUL;
        end
      end

      S_RND_MUL: begin
        if (tot_q == '0) begin
          rem_d   = '0;
          rsh_d   = rand_q;
          cnt_d   = '0;
          state_d = S_RND_DIV;
        end else begin
          r_d     = prod[PR_W-1:RW];
          cum_d   = '0;
          ei_d    = '0;
          e_idx   = '0;
          state_d = S_RND_SCAN;
        end
      end

      S_RND_SCAN: begin
        cum_d = alu_res;
        if ((r_q < alu_res) || (ei_q == deg_q - DEG_W'(1))) begin
          cur_d   = e_tgt;
          rv_d    = 1'b1;
          on_d    = e_tgt;
          os_d    = bit_of(e_tgt, present_q) ? gts_pkg::ST_NODE : gts_pkg::ST_ABSENT;
          state_d = S_IDLE;
        end else begin
          ei_d  = ei_q + DEG_W'(1);
          e_idx = ei_d;
        end
      end

      // Bit-serial remainder of the draw by the degree.
      S_RND_DIV: begin
        alu_op = gts_pkg::ALU_SUB;
        alu_a  = trial;
        alu_b  = TOT_W'(deg_q);
        rem_d  = alu_borrow ? trial : alu_res;
        rsh_d  = {rsh_q[RW-2:0], 1'b0};
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          e_idx   = DEG_W'(rem_d);
          state_d = S_RND_PICK;
        end
      end

      S_RND_PICK: begin
        cur_d   = e_tgt;
        rv_d    = 1'b1;
        on_d    = e_tgt;
        os_d    = bit_of(e_tgt, present_q) ? gts_pkg::ST_NODE : gts_pkg::ST_ABSENT;
        state_d = S_IDLE;
      end

      // Depth-first: pop until an unvisited node turns up.
      S_DFS_POP: begin
        if (tail_q == '0) begin
          done_d  = 1'b1;
          rv_d    = 1'b1;
          on_d    = cur_q;
          os_d    = gts_pkg::ST_DONE;
          state_d = S_IDLE;
        end else begin
          tail_d     = tail_q - WP_W'(1);
          work_raddr = WA_W'(tail_d);
          state_d    = S_DFS_CHK;
        end
      end

      S_DFS_CHK: begin
        deg_raddr = IDX_W'(work_rdata);
        if (bit_of(work_rdata, visited_q)) begin
          state_d = S_DFS_POP;
        end else begin
          if (in_range(work_rdata)) begin
            visited_d[IDX_W'(work_rdata)] = 1'b1;
          end
          cur_d = work_rdata;
          if (!bit_of(work_rdata, present_q)) begin
            rv_d    = 1'b1;
            on_d    = work_rdata;
            os_d    = gts_pkg::ST_ABSENT;
            state_d = S_IDLE;
          end else begin
            state_d = S_DFS_DEG;
          end
        end
      end

      S_DFS_DEG: begin
        st_d = gts_pkg::ST_NODE;
        if (deg_rdata == '0) begin
          rv_d    = 1'b1;
          on_d    = cur_q;
          os_d    = gts_pkg::ST_NODE;
          state_d = S_IDLE;
        end else begin
          ei_d    = deg_rdata - DEG_W'(1);
          e_idx   = ei_d;
          state_d = S_DFS_EXP;
        end
      end

      // Neighbours go on the stack last slot first.
      S_DFS_EXP: begin
        if (!bit_of(e_tgt, visited_q)) begin
          if (room) begin
            work_we = 1'b1;
            tail_d  = tail_q + WP_W'(1);
          end else begin
            st_d = gts_pkg::ST_OVERFLOW;
          end
        end
        if (ei_q == '0) begin
          rv_d    = 1'b1;
          on_d    = cur_q;
          os_d    = st_d;
          state_d = S_IDLE;
        end else begin
          ei_d  = ei_q - DEG_W'(1);
          e_idx = ei_d;
        end
      end

      // Breadth-first: take the head of the queue.
      S_BFS_POP: begin
        if ((head_q >= tail_q) || (32'(head_q) >= WORK_DEPTH)) begin
          done_d  = 1'b1;
          rv_d    = 1'b1;
          on_d    = cur_q;
          os_d    = gts_pkg::ST_DONE;
          state_d = S_IDLE;
        end else begin
          work_raddr = WA_W'(head_q);
          head_d     = head_q + WP_W'(1);
          state_d    = S_BFS_CHK;
        end
      end

      S_BFS_CHK: begin
        deg_raddr = IDX_W'(work_rdata);
        cur_d     = work_rdata;
        if (!bit_of(work_rdata, present_q)) begin
          rv_d    = 1'b1;
          on_d    = work_rdata;
          os_d    = gts_pkg::ST_ABSENT;
          state_d = S_IDLE;
        end else begin
          state_d = S_BFS_DEG;
        end
      end

      S_BFS_DEG: begin
        st_d  = gts_pkg::ST_NODE;
        deg_d = deg_rdata;
        if (deg_rdata == '0) begin
          rv_d    = 1'b1;
          on_d    = cur_q;
          os_d    = gts_pkg::ST_NODE;
          state_d = S_IDLE;
        end else begin
          ei_d    = '0;
          e_idx   = '0;
          state_d = S_BFS_EXP;
        end
      end

      // Neighbours are marked as they enter the queue.
      S_BFS_EXP: begin
        if (!bit_of(e_tgt, visited_q)) begin
          if (room) begin
            work_we = 1'b1;
            tail_d  = tail_q + WP_W'(1);
            if (in_range(e_tgt)) begin
              visited_d[IDX_W'(e_tgt)] = 1'b1;
            end
          end else begin
            st_d = gts_pkg::ST_OVERFLOW;
          end
        end
        if (ei_q == deg_q - DEG_W'(1)) begin
          rv_d    = 1'b1;
          on_d    = cur_q;
          os_d    = st_d;
          state_d = S_IDLE;
        end else begin
          ei_d  = ei_q + DEG_W'(1);
          e_idx = ei_d;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= gts_pkg::MODE_RANDOM;
      present_q <= '0;
      visited_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      cur_q     <= '0;
      cv_q      <= 1'b0;
      rs_q      <= '0;
      sv_q      <= 1'b0;
      init_q    <= 1'b0;
      done_q    <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      present_q <= present_d;
      visited_q <= visited_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cur_q     <= cur_d;
      cv_q      <= cv_d;
      rs_q      <= rs_d;
      sv_q      <= sv_d;
      init_q    <= init_d;
      done_q    <= done_d;
      rv_q      <= rv_d;
    end
  end

  // Item and datapath registers.
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    node_q  <= node_d;
    slot_q  <= slot_d;
    tgt_q   <= tgt_d;
    wgt_q   <= wgt_d;
    degin_q <= degin_d;
    hs_q    <= hs_d;
    rand_q  <= rand_d;
    deg_q   <= deg_d;
    ei_q    <= ei_d;
    tot_q   <= tot_d;
    cum_q   <= cum_d;
    r_q     <= r_d;
    rem_q   <= rem_d;
    rsh_q   <= rsh_d;
    cnt_q   <= cnt_d;
    st_q    <= st_d;
    on_q    <= on_d;
    os_q    <= os_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign out_node_o     = on_q;
  assign status_o       = os_q;

endmodule

>>> rtl/gts_checker.sv
`timescale 1ns / 1ps

module gts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         result_valid_o,
  input logic [gts_pkg::STATUS_W-1:0] status_o
);

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result goes out only once the block is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Busy drops exactly when the item's result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy fell without a result");

  // One result per item: strobes never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");

  // An acknowledge never shows up unless an item was in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == gts_pkg::ST_ACK) |-> $past(busy))
    else $error("acknowledge without an item");

endmodule

bind graph_traversal_stepper gts_checker u_gts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o)
);
